// File: rtl/core/imu_oma_pkg.sv
// Shared types and constants of the IMU offset / moving-average block.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps
`default_nettype none

package imu_oma_pkg;

  localparam int unsigned NUM_CH    = 6;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // channel order: acc x/y/z, then gyro x/y/z
  localparam logic [CH_W-1:0] CH_FIRST_GYRO = 3'd3;
  localparam logic [CH_W-1:0] CH_LAST       = 3'd5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACC_OFF_X  = 3'd0,
    REG_ACC_OFF_Y  = 3'd1,
    REG_ACC_OFF_Z  = 3'd2,
    REG_GYRO_OFF_X = 3'd3,
    REG_GYRO_OFF_Y = 3'd4,
    REG_GYRO_OFF_Z = 3'd5,
    REG_DPS_SCALE  = 3'd6,
    REG_RAD_SCALE  = 3'd7
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic signed [15:0] RST_ACC_OFF_X  = 16'sd256;
  localparam logic signed [15:0] RST_ACC_OFF_Y  = 16'sd20;
  localparam logic signed [15:0] RST_ACC_OFF_Z  = 16'sd3720;
  localparam logic signed [23:0] RST_GYRO_OFF_X = -24'sd20241;
  localparam logic signed [23:0] RST_GYRO_OFF_Y = 24'sd5294;
  localparam logic signed [23:0] RST_GYRO_OFF_Z = -24'sd227;
  localparam logic [15:0]        RST_DPS_SCALE  = 16'd4000;
  localparam logic [15:0]        RST_RAD_SCALE  = 16'd1144;

  typedef struct packed {
    logic signed [15:0] raw_acc_x;
    logic signed [15:0] raw_acc_y;
    logic signed [15:0] raw_acc_z;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
    logic signed [15:0] raw_gyro_z;
  } imu_in_t;

  typedef struct packed {
    logic signed [23:0] mean_acc_x;
    logic signed [23:0] mean_acc_y;
    logic signed [23:0] mean_acc_z;
    logic signed [23:0] mean_gyro_x;
    logic signed [23:0] mean_gyro_y;
    logic signed [23:0] mean_gyro_z;
    logic signed [23:0] rate_deg_x;
    logic signed [23:0] rate_deg_y;
    logic signed [23:0] rate_deg_z;
    logic signed [31:0] rate_rad_x;
    logic signed [31:0] rate_rad_y;
    logic signed [31:0] rate_rad_z;
  } imu_out_t;

  // controller -> datapath
  typedef struct packed {
    logic            capture;  // latch input item
    logic            rd;       // correct sample, read oldest history entry
    logic            acc;      // update running sum, write history
    logic            mul;      // reciprocal multiply
    logic            fix;      // quotient correction, store mean
    logic            deg;      // deg/s scaling
    logic            rad;      // rad/s scaling
    logic            load;     // move result into output register
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/imu_offset_moving_average.sv
// Top level of the IMU offset / moving-average block: sequencer plus datapath.
// Depends on imu_oma_pkg, imu_oma_ctrl and imu_oma_dp.
//
//   channel | signals                         | transfer
//   --------+---------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data     | one six-axis sample / item
//   result  | out_valid, out_ready, out_data  | one result / item
//   config  | cfg_we, cfg_addr, cfg_wdata     | one register per write
//
// in_ready drops once an item is accepted and stays low through four steps per
// channel (correct + history read, sum update, reciprocal multiply, quotient
// fix) through the one shared datapath, two more per gyro channel (deg/s and
// rad/s multiplies) and the load of the output register; the load waits while
// the previous result in the output register has not yet been taken.
// Reset (rst_n, synchronous) zeroes the running sums, window pointer and fill
// count; history entries count as zero until the window has filled once.
// The finished result sits in the output register, so the next item is taken
// while it waits; the block only stalls if a second result is ready first.
`timescale 1ns / 1ps
`default_nettype none

module imu_offset_moving_average #(
  parameter int WINDOW_LEN = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  imu_oma_pkg::imu_in_t                     in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output imu_oma_pkg::imu_out_t                    out_data,
  input  wire logic                                cfg_we,
  input  wire logic [imu_oma_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [imu_oma_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import imu_oma_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks the channels of one item
  imu_oma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // shared datapath, history store and output register
  imu_oma_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/imu_oma_ctrl.sv
// Sequencer of the IMU offset / moving-average block: steps one datapath
// over the six channels of an item. Depends on imu_oma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_oma_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output imu_oma_pkg::dp_cmd_t      cmd,
  input  imu_oma_pkg::dp_stat_t     stat
);
  import imu_oma_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD   = 8'b0000_0010,
    ST_ACC  = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_FIX  = 8'b0001_0000,
    ST_DEG  = 8'b0010_0000,
    ST_RAD  = 8'b0100_0000,
    ST_WB   = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RD;
          ch_nxt    = '0;
        end
      end
      ST_RD:  state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_FIX;
      ST_FIX: begin
        if (ch_r >= CH_FIRST_GYRO) begin
          state_nxt = ST_DEG;
        end else begin
          state_nxt = ST_RD;
          ch_nxt    = ch_r + 3'd1;
        end
      end
      ST_DEG: state_nxt = ST_RAD;
      ST_RAD: begin
        if (ch_r == CH_LAST) begin
          state_nxt = ST_WB;
        end else begin
          state_nxt = ST_RD;
          ch_nxt    = ch_r + 3'd1;
        end
      end
      ST_WB: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = in_ready && in_valid;
    cmd.rd      = (state_r == ST_RD);
    cmd.acc     = (state_r == ST_ACC);
    cmd.mul     = (state_r == ST_MUL);
    cmd.fix     = (state_r == ST_FIX);
    cmd.deg     = (state_r == ST_DEG);
    cmd.rad     = (state_r == ST_RAD);
    cmd.load    = (state_r == ST_WB) && !stat.out_busy;
    cmd.ch      = ch_r;
  end

endmodule

`default_nettype wire

// File: rtl/core/imu_oma_dp.sv
// Datapath of the IMU offset / moving-average block: offset correction,
// history memory, running sums, constant divide, gyro scaling, config and
// output registers. Depends on imu_oma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_oma_dp #(
  parameter int WINDOW_LEN = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  imu_oma_pkg::dp_cmd_t                        cmd,
  output imu_oma_pkg::dp_stat_t                       stat,
  input  imu_oma_pkg::imu_in_t                        in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output imu_oma_pkg::imu_out_t                       out_data,
  input  wire logic                                   cfg_we,
  input  wire logic [imu_oma_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [imu_oma_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import imu_oma_pkg::*;

  localparam int unsigned PW    = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned AW    = CH_W + PW;
  localparam int unsigned MEM_D = 1 << AW;
  localparam int unsigned SUM_W = 16 + $clog2(WINDOW_LEN);
  localparam int unsigned MAG_W = SUM_W + 8;
  // floor(2^32 / N); estimate is exact or one short since mag < 2^32
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(WINDOW_LEN));
  localparam logic [MAG_W-1:0] WLEN_M = MAG_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0] WLEN_C = CNT_W'(WINDOW_LEN);
  localparam logic [PW-1:0]    PTR_LAST = PW'(WINDOW_LEN - 1);

  // configuration
  logic signed [15:0] acc_off_r [0:2];
  logic signed [23:0] gyro_off_r [0:2];
  logic [15:0]        dps_r, rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_off_r[0]  <= RST_ACC_OFF_X;
      acc_off_r[1]  <= RST_ACC_OFF_Y;
      acc_off_r[2]  <= RST_ACC_OFF_Z;
      gyro_off_r[0] <= RST_GYRO_OFF_X;
      gyro_off_r[1] <= RST_GYRO_OFF_Y;
      gyro_off_r[2] <= RST_GYRO_OFF_Z;
      dps_r         <= RST_DPS_SCALE;
      rad_r         <= RST_RAD_SCALE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACC_OFF_X:  acc_off_r[0]  <= cfg_wdata[15:0];
        REG_ACC_OFF_Y:  acc_off_r[1]  <= cfg_wdata[15:0];
        REG_ACC_OFF_Z:  acc_off_r[2]  <= cfg_wdata[15:0];
        REG_GYRO_OFF_X: gyro_off_r[0] <= cfg_wdata;
        REG_GYRO_OFF_Y: gyro_off_r[1] <= cfg_wdata;
        REG_GYRO_OFF_Z: gyro_off_r[2] <= cfg_wdata;
        REG_DPS_SCALE:  dps_r         <= cfg_wdata[15:0];
        REG_RAD_SCALE:  rad_r         <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input item
  imu_in_t in_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  // offset correction
  logic signed [15:0] raw;
  logic signed [15:0] aoff;
  logic signed [23:0] goff;
  logic               is_gyro;
  logic signed [16:0] acc_diff;
  logic signed [24:0] gyr_d;
  logic signed [16:0] gyr_q;
  logic signed [15:0] corr;

  always_comb begin
    raw     = in_r.raw_acc_x;
    aoff    = acc_off_r[0];
    goff    = gyro_off_r[0];
    is_gyro = 1'b0;
    case (cmd.ch)
      3'd0: begin raw = in_r.raw_acc_x;  aoff = acc_off_r[0]; end
      3'd1: begin raw = in_r.raw_acc_y;  aoff = acc_off_r[1]; end
      3'd2: begin raw = in_r.raw_acc_z;  aoff = acc_off_r[2]; end
      3'd3: begin raw = in_r.raw_gyro_x; goff = gyro_off_r[0]; is_gyro = 1'b1; end
      3'd4: begin raw = in_r.raw_gyro_y; goff = gyro_off_r[1]; is_gyro = 1'b1; end
      3'd5: begin raw = in_r.raw_gyro_z; goff = gyro_off_r[2]; is_gyro = 1'b1; end
      default: ;
    endcase
    acc_diff = {raw[15], raw} - {aoff[15], aoff};
    gyr_d    = {raw[15], raw, 8'h00} - {goff[23], goff};
    // truncate toward zero: floor, plus one for a negative value with a fraction
    gyr_q    = gyr_d[24:8] + {16'd0, gyr_d[24] && (gyr_d[7:0] != 8'h00)};
    corr     = sat16(is_gyro ? gyr_q : acc_diff);
  end

  // history memory, one row of 2^PW entries per channel
  logic signed [15:0] hist_mem [0:MEM_D-1];
  logic signed [15:0] old_r;
  logic signed [15:0] corr_r;
  logic [PW-1:0]      ptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic [AW-1:0]      addr;

  assign addr = {cmd.ch, ptr_r};

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      old_r  <= hist_mem[addr];
      corr_r <= corr;
    end
    if (cmd.acc) begin
      hist_mem[addr] <= corr_r;
    end
  end

  // running sums; oldest entry counts only once the window has filled
  logic signed [SUM_W-1:0] sum_r [0:NUM_CH-1];
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] cur_sum_r;
  logic signed [SUM_W-1:0] old_ext;
  logic                    win_full;

  assign win_full = (fill_r == WLEN_C);
  assign old_ext  = win_full ? SUM_W'(old_r) : '0;
  assign sum_nxt  = sum_r[cmd.ch] + SUM_W'(corr_r) - old_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i] <= '0;
      end
    end else if (cmd.acc) begin
      sum_r[cmd.ch] <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      cur_sum_r <= sum_nxt;
    end
  end

  // mean = trunc(sum * 256 / N) via reciprocal multiply and one correction
  logic [SUM_W-1:0]    mag_abs;
  logic [MAG_W-1:0]    mag, mag_r, q_est_r, rem, q_fix;
  logic [MAG_W+31:0]   prod_q;
  logic                neg_r;
  logic signed [23:0]  mean;

  assign mag_abs = cur_sum_r[SUM_W-1] ? SUM_W'(-cur_sum_r) : SUM_W'(cur_sum_r);
  assign mag     = {mag_abs, 8'h00};
  assign prod_q  = (MAG_W+32)'(mag) * (MAG_W+32)'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mag_r   <= mag;
      q_est_r <= prod_q[MAG_W+31:32];
      neg_r   <= cur_sum_r[SUM_W-1];
    end
  end

  assign rem   = mag_r - q_est_r * WLEN_M;
  assign q_fix = q_est_r + {{(MAG_W-1){1'b0}}, (rem >= WLEN_M)};
  assign mean  = neg_r ? -24'(q_fix) : 24'(q_fix);

  // gyro scaling with floor shifts
  logic signed [23:0] mean_r [0:NUM_CH-1];
  logic signed [23:0] deg_r  [0:2];
  logic signed [31:0] rad_r_a [0:2];
  logic signed [23:0] cur_mean_r, cur_deg_r;
  logic signed [40:0] prod_deg, prod_rad;
  logic [1:0]         gidx;

  assign gidx     = 2'(cmd.ch - CH_FIRST_GYRO);
  assign prod_deg = cur_mean_r * $signed({1'b0, dps_r});
  assign prod_rad = cur_deg_r * $signed({1'b0, rad_r});

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      mean_r[cmd.ch] <= mean;
      cur_mean_r     <= mean;
    end
    if (cmd.deg) begin
      deg_r[gidx] <= prod_deg[39:16];
      cur_deg_r   <= prod_deg[39:16];
    end
    if (cmd.rad) begin
      rad_r_a[gidx] <= prod_rad[39:8];
    end
  end

  // window pointer advances once per item; fill count likewise until the window is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.load) begin
      ptr_r <= (ptr_r == PTR_LAST) ? '0 : ptr_r + PW'(1);
      if (!win_full) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  // output register
  logic     out_valid_r;
  imu_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.mean_acc_x  <= mean_r[0];
      out_data_r.mean_acc_y  <= mean_r[1];
      out_data_r.mean_acc_z  <= mean_r[2];
      out_data_r.mean_gyro_x <= mean_r[3];
      out_data_r.mean_gyro_y <= mean_r[4];
      out_data_r.mean_gyro_z <= mean_r[5];
      out_data_r.rate_deg_x  <= deg_r[0];
      out_data_r.rate_deg_y  <= deg_r[1];
      out_data_r.rate_deg_z  <= deg_r[2];
      out_data_r.rate_rad_x  <= rad_r_a[0];
      out_data_r.rate_rad_y  <= rad_r_a[1];
      out_data_r.rate_rad_z  <= rad_r_a[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

`default_nettype wire

// File: rtl/core/imu_oma_chk.sv
// Port-level checks of the IMU offset / moving-average block, bound to the
// top level. Depends on imu_oma_pkg and imu_offset_moving_average.
`timescale 1ns / 1ps
`default_nettype none

module imu_oma_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input imu_oma_pkg::imu_out_t      out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a new result only appears at the end of the work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready) && in_ready)
    else $error("result appeared without an item in work");

  // an idle block with no input stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("block left idle without an item");

endmodule

bind imu_offset_moving_average imu_oma_chk u_chk (.*);

`default_nettype wire
